// ===== rtl/hsv_color_blob_centroid_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef HSV_COLOR_BLOB_CENTROID_TOP_ASSERT_SVH
`define HSV_COLOR_BLOB_CENTROID_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define HCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HCB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/hcb_pkg.sv =====
package hcb_pkg;
  localparam int MaxWidth = 2048;
  localparam int MaxPixels = 4194304;
  localparam int ColW = 11;
  localparam int SumW = 33;
  localparam int CntW = 23;
  localparam int DivSteps = 33;
  localparam int ConvSteps = 9;

  // Register indexes.
  localparam logic [2:0] RegWidth = 3'd0;
  localparam logic [2:0] RegHueLo = 3'd1;
  localparam logic [2:0] RegHueHi = 3'd2;
  localparam logic [2:0] RegSatLo = 3'd3;
  localparam logic [2:0] RegSatHi = 3'd4;
  localparam logic [2:0] RegValLo = 3'd5;
  localparam logic [2:0] RegValHi = 3'd6;
  localparam logic [2:0] RegMinArea = 3'd7;

  typedef struct packed {
    logic [11:0] image_width;
    logic [7:0]  hue_low;
    logic [7:0]  hue_high;
    logic [7:0]  sat_low;
    logic [7:0]  sat_high;
    logic [7:0]  val_low;
    logic [7:0]  val_high;
    logic [22:0] min_area;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture incoming pixel
    logic conv_start; // load the saturation and hue dividers
    logic conv_step;  // one saturation and hue division step
    logic acc;        // accumulate the converted pixel
    logic div_start;  // begin the centroid division
    logic div_step;   // one restoring division step
    logic clear;      // clear frame accumulators
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last;       // captured pixel closed the frame
    logic conv_done;  // saturation and hue quotients complete
    logic div_needed; // count exceeded minimum area
    logic div_done;   // quotient complete
  } sts_t;
endpackage

// ===== rtl/hcb_if.sv =====
interface hcb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       last_pixel;
  modport source (output valid, blue, green, red, last_pixel, input ready);
  modport sink (input valid, blue, green, red, last_pixel, output ready);
endinterface

interface hcb_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] centroid_x;
  logic signed [23:0] area;
  logic               found;
  modport source (output valid, centroid_x, area, found, input ready);
  modport sink (input valid, centroid_x, area, found, output ready);
endinterface

// ===== rtl/hsv_color_blob_centroid_top.sv =====
// A frame-closing pixel shows its word after capture, conversion, accumulation
// and the area check, and after the 33-step centroid division when it runs.
// Pixels are taken one at a time, each through capture, the 9-step saturation
// and hue dividers and accumulate; a waiting word holds off further pixels.
// Reset: synchronous active-low rst_n restores register defaults and clears
// the column, sum and count.
module hsv_color_blob_centroid_top (
  input  logic         clk,
  input  logic         rst_n,
  hcb_in_if.sink       in_ch,
  hcb_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  hcb_pkg::cfg_t cfg;
  hcb_pkg::cmd_t cmd;
  hcb_pkg::sts_t sts;

  hcb_regs u_regs (.clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite,
    .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg);

  hcb_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts, .cmd);

  hcb_dp u_dp (.clk, .rst_n, .cfg, .blue(in_ch.blue), .green(in_ch.green),
    .red(in_ch.red), .last_pixel(in_ch.last_pixel), .cmd, .sts,
    .centroid_x(out_ch.centroid_x), .area(out_ch.area), .found(out_ch.found));
endmodule

// ===== rtl/hcb_regs.sv =====
module hcb_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output hcb_pkg::cfg_t      cfg
);
  hcb_pkg::cfg_t cfg_r;
  logic [2:0] idx;

  assign idx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg = cfg_r;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width <= 12'd640;
      cfg_r.hue_low <= 8'd32;
      cfg_r.hue_high <= 8'd43;
      cfg_r.sat_low <= 8'd50;
      cfg_r.sat_high <= 8'd255;
      cfg_r.val_low <= 8'd125;
      cfg_r.val_high <= 8'd255;
      cfg_r.min_area <= 23'd250;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        hcb_pkg::RegWidth:   cfg_r.image_width <= cfg_pwdata[11:0];
        hcb_pkg::RegHueLo:   cfg_r.hue_low <= cfg_pwdata[7:0];
        hcb_pkg::RegHueHi:   cfg_r.hue_high <= cfg_pwdata[7:0];
        hcb_pkg::RegSatLo:   cfg_r.sat_low <= cfg_pwdata[7:0];
        hcb_pkg::RegSatHi:   cfg_r.sat_high <= cfg_pwdata[7:0];
        hcb_pkg::RegValLo:   cfg_r.val_low <= cfg_pwdata[7:0];
        hcb_pkg::RegValHi:   cfg_r.val_high <= cfg_pwdata[7:0];
        hcb_pkg::RegMinArea: cfg_r.min_area <= cfg_pwdata[22:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      hcb_pkg::RegWidth:   cfg_prdata = {20'd0, cfg_r.image_width};
      hcb_pkg::RegHueLo:   cfg_prdata = {24'd0, cfg_r.hue_low};
      hcb_pkg::RegHueHi:   cfg_prdata = {24'd0, cfg_r.hue_high};
      hcb_pkg::RegSatLo:   cfg_prdata = {24'd0, cfg_r.sat_low};
      hcb_pkg::RegSatHi:   cfg_prdata = {24'd0, cfg_r.sat_high};
      hcb_pkg::RegValLo:   cfg_prdata = {24'd0, cfg_r.val_low};
      hcb_pkg::RegValHi:   cfg_prdata = {24'd0, cfg_r.val_high};
      hcb_pkg::RegMinArea: cfg_prdata = {9'd0, cfg_r.min_area};
      default:             cfg_prdata = 32'd0;
    endcase
  end
endmodule

// ===== rtl/hcb_ctrl.sv =====
module hcb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  hcb_pkg::sts_t  sts,
  output hcb_pkg::cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_CONV, S_ACC, S_CHK, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  // Commands and next state.
  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.conv_start = 1'b1;
        state_nxt = S_CONV;
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        // The pixel is counted first; a frame end then checks the area.
        cmd.acc = 1'b1;
        state_nxt = sts.last ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        cmd.div_start = 1'b1;
        state_nxt = sts.div_needed ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.clear = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ===== rtl/hcb_dp.sv =====
module hcb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  hcb_pkg::cfg_t      cfg,
  input  logic [7:0]         blue,
  input  logic [7:0]         green,
  input  logic [7:0]         red,
  input  logic               last_pixel,
  input  hcb_pkg::cmd_t      cmd,
  output hcb_pkg::sts_t      sts,
  output logic signed [11:0] centroid_x,
  output logic signed [23:0] area,
  output logic               found
);
  logic [7:0] b_r, g_r, r_r;
  logic       last_r;
  logic [hcb_pkg::ColW-1:0] col_r;
  logic [hcb_pkg::SumW-1:0] sum_r;
  logic [hcb_pkg::CntW:0]   cnt_r;
  logic [hcb_pkg::SumW-1:0] quo_r;
  logic [hcb_pkg::CntW:0]   rem_r;
  logic [5:0]               step_r;
  logic [17:0] s_rem_r, h_rem_r;
  logic [16:0] s_dsh_r, h_dsh_r;
  logic [8:0]  s_quo_r, h_quo_r;
  logic [3:0]  conv_r;
  logic [11:0] cx_r;
  logic [23:0] area_r;
  logic        found_r;

  // HSV conversion of the captured pixel.
  logic [7:0] v, mn, diff;
  logic signed [18:0] bs, gs, rs, ds, num;
  logic [17:0] s_dvd, h_dvd;
  logic s_ge, h_ge;
  logic [8:0] h_wrap;
  logic [7:0] s, h;
  logic in_mask;
  logic [11:0] w_eff;
  logic [11:0] col_cur;
  logic [11:0] col_inc;
  logic [hcb_pkg::CntW:0] rem_sh, rem_sub;

  always_comb begin
    v = b_r;
    if (g_r > v) v = g_r;
    if (r_r > v) v = r_r;
    mn = b_r;
    if (g_r < mn) mn = g_r;
    if (r_r < mn) mn = r_r;
    diff = v - mn;
    bs = 19'(b_r);
    gs = 19'(g_r);
    rs = 19'(r_r);
    ds = 19'(diff);
    // Hue numerator with the 180*diff offset folded in, so it is never negative.
    if (v == r_r)
      num = 19'sd30 * (gs - bs) + 19'sd180 * ds;
    else if (v == g_r)
      num = 19'sd240 * ds + 19'sd30 * (bs - rs);
    else
      num = 19'sd300 * ds + 19'sd30 * (rs - gs);
    // Dividends of the two rounded divisions.
    s_dvd = 18'(18'd510 * 18'(diff) + 18'(v));
    h_dvd = 18'(19'sd2 * num + ds);
    s_ge = s_rem_r >= {1'b0, s_dsh_r};
    h_ge = h_rem_r >= {1'b0, h_dsh_r};
    // The hue quotient lies in 150..330, so one subtraction wraps it.
    h_wrap = (h_quo_r >= 9'd180) ? h_quo_r - 9'd180 : h_quo_r;
    s = (v == 8'd0) ? 8'd0 : s_quo_r[7:0];
    h = (diff == 8'd0) ? 8'd0 : h_wrap[7:0];
    in_mask = h >= cfg.hue_low && h <= cfg.hue_high &&
              s >= cfg.sat_low && s <= cfg.sat_high &&
              v >= cfg.val_low && v <= cfg.val_high;
    w_eff = (cfg.image_width == 12'd0) ? 12'd1 :
            (cfg.image_width > 12'(hcb_pkg::MaxWidth)) ? 12'(hcb_pkg::MaxWidth) :
            cfg.image_width;
    col_cur = (12'(col_r) >= w_eff) ? 12'd0 : 12'(col_r);
    col_inc = col_cur + 12'd1;
    rem_sh = {rem_r[hcb_pkg::CntW-1:0], quo_r[hcb_pkg::SumW-1]};
    rem_sub = rem_sh - cnt_r;
  end

  assign sts = '{last: last_r,
                 conv_done: conv_r == 4'd1,
                 div_needed: cnt_r > {1'b0, cfg.min_area},
                 div_done: step_r == 6'd1};
  assign centroid_x = cx_r;
  assign area = area_r;
  assign found = found_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_r <= blue; g_r <= green; r_r <= red; last_r <= last_pixel;
    end
  end

  // Saturation and hue dividers: one quotient bit per step, MSB first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_rem_r <= '0; s_dsh_r <= '0; s_quo_r <= '0;
      h_rem_r <= '0; h_dsh_r <= '0; h_quo_r <= '0;
      conv_r <= '0;
    end else if (cmd.conv_start) begin
      s_rem_r <= s_dvd; s_dsh_r <= {v, 9'd0}; s_quo_r <= '0;
      h_rem_r <= h_dvd; h_dsh_r <= {diff, 9'd0}; h_quo_r <= '0;
      conv_r <= 4'(hcb_pkg::ConvSteps);
    end else if (cmd.conv_step) begin
      if (s_ge) s_rem_r <= s_rem_r - {1'b0, s_dsh_r};
      s_quo_r <= {s_quo_r[7:0], s_ge};
      s_dsh_r <= s_dsh_r >> 1;
      if (h_ge) h_rem_r <= h_rem_r - {1'b0, h_dsh_r};
      h_quo_r <= {h_quo_r[7:0], h_ge};
      h_dsh_r <= h_dsh_r >> 1;
      conv_r <= conv_r - 4'd1;
    end
  end

  // Accumulators, centroid divider and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; sum_r <= '0; cnt_r <= '0;
      quo_r <= '0; rem_r <= '0; step_r <= '0;
      cx_r <= '0; area_r <= '0; found_r <= 1'b0;
    end else if (cmd.clear) begin
      col_r <= '0; sum_r <= '0; cnt_r <= '0;
    end else if (cmd.acc) begin
      col_r <= (col_inc >= w_eff) ? '0 : col_inc[hcb_pkg::ColW-1:0];
      if (in_mask && cnt_r < hcb_pkg::MaxPixels[hcb_pkg::CntW:0]) begin
        sum_r <= sum_r + {{(hcb_pkg::SumW-12){1'b0}}, col_cur};
        cnt_r <= cnt_r + {{hcb_pkg::CntW{1'b0}}, 1'b1};
      end
    end else if (cmd.div_start) begin
      quo_r <= sum_r;
      rem_r <= '0;
      step_r <= 6'(hcb_pkg::DivSteps);
      if (sts.div_needed) begin
        area_r <= cnt_r; found_r <= 1'b1;
      end else begin
        cx_r <= 12'hFFF; area_r <= 24'hFFFFFF; found_r <= 1'b0;
      end
    end else if (cmd.div_step) begin
      if (!rem_sub[hcb_pkg::CntW]) rem_r <= rem_sub;
      else rem_r <= rem_sh;
      quo_r <= {quo_r[hcb_pkg::SumW-2:0], !rem_sub[hcb_pkg::CntW]};
      step_r <= step_r - 6'd1;
      if (step_r == 6'd1)
        cx_r <= {quo_r[10:0], !rem_sub[hcb_pkg::CntW]};
    end
  end
endmodule

// ===== rtl/hcb_checker.sv =====
`include "hsv_color_blob_centroid_top_assert.svh"
module hcb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [11:0] centroid_x,
  input logic signed [23:0] area,
  input logic               found
);
  // A missed result reports -1 in both fields.
  `HCB_ASSERT_IMP(a_miss, out_valid && !found, centroid_x == -12'sd1 && area == -24'sd1)
  // A found blob has a positive area.
  `HCB_ASSERT_IMP(a_hit, out_valid && found, area > 24'sd0)
  // No pixel is taken while a result waits.
  `HCB_ASSERT_IMP(a_block, out_valid, !in_ready)
  // A pixel is never taken in two consecutive cycles.
  `HCB_ASSERT_NXT(a_gap, in_valid && in_ready, !in_ready)
endmodule

bind hsv_color_blob_centroid_top hcb_checker u_chk (.clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .centroid_x(out_ch.centroid_x), .area(out_ch.area),
  .found(out_ch.found));
